FILE: rtl/audio_ring_buffer_accumulator_defines.svh
// Assertion macros shared by the ring buffer checker.
`ifndef AUDIO_RING_BUFFER_ACCUMULATOR_DEFINES_SVH
`define AUDIO_RING_BUFFER_ACCUMULATOR_DEFINES_SVH

// Clocked assertion, switched off while reset is held.
`define ARB_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also checks during reset.
`define ARB_ASSERT_ANY(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/arb_pkg.sv
// Shared constants, operation codes and types of the audio ring buffer.
package arb_pkg;

    // Default geometry
    localparam int DEF_DEPTH       = 4096;
    localparam int DEF_SAMPLE_BITS = 24;
    localparam int RST_RING_LENGTH = 4096;

    // Request operation codes
    localparam int FUNC_W = 4;
    localparam logic [FUNC_W-1:0] FUNC_WRITE        = 4'd0;
    localparam logic [FUNC_W-1:0] FUNC_WRITE_ADD    = 4'd1;
    localparam logic [FUNC_W-1:0] FUNC_READ         = 4'd2;
    localparam logic [FUNC_W-1:0] FUNC_READ_ADD     = 4'd3;
    localparam logic [FUNC_W-1:0] FUNC_READ_ADD_CLR = 4'd4;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR_SLOT   = 4'd5;
    localparam logic [FUNC_W-1:0] FUNC_ADV_WRITE    = 4'd6;
    localparam logic [FUNC_W-1:0] FUNC_ADV_READ     = 4'd7;
    localparam logic [FUNC_W-1:0] FUNC_SET_WRITE    = 4'd8;
    localparam logic [FUNC_W-1:0] FUNC_SET_READ     = 4'd9;
    localparam logic [FUNC_W-1:0] FUNC_SET_BOTH     = 4'd10;
    localparam logic [FUNC_W-1:0] FUNC_RD_TO_WR     = 4'd11;
    localparam logic [FUNC_W-1:0] FUNC_WR_TO_RD     = 4'd12;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR_ALL    = 4'd13;

    // Register port
    localparam int APB_DW  = 32;
    localparam int PADDR_W = 3;
    localparam logic REG_RING_LENGTH = 1'b0;   // register index, paddr[2]

    // Memory work that a request leaves for the second stage
    typedef struct packed {
        logic wr_en;     // write back the slot
        logic wr_zero;   // write back zero
        logic wr_add;    // write back slot + sample
        logic rd_res;    // result carries slot data
        logic rd_add;    // result is slot + sample
        logic clr_all;   // start a full clear sweep
    } t_op;

endpackage

FILE: rtl/arb_ram.sv
// Simple dual-port sample memory, one write and one registered read port.
module arb_ram #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 24,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, data holds while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/arb_clr.sv
// Clear sweeper: zeroes memory slots one per cycle after reset, clear_all or a length change.
module arb_clr #(
    parameter int DEPTH = 4096,
    localparam int AW   = $clog2(DEPTH),
    localparam int LEN_W = $clog2(DEPTH + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start_all,
    input  logic             i_start_from,
    input  logic [LEN_W-1:0] i_from,
    output logic             o_busy,
    output logic [AW-1:0]    o_addr
);

    localparam logic [LEN_W-1:0] LAST  = LEN_W'(DEPTH - 1);
    localparam logic [LEN_W-1:0] LIMIT = LEN_W'(DEPTH);

    logic             r_busy, n_busy;
    logic [LEN_W-1:0] r_ptr, n_ptr;
    logic [LEN_W-1:0] from_sel;

    // a new start point never skips slots still pending from a running sweep
    always_comb begin
        from_sel = i_from;
        if (r_busy && (r_ptr < i_from)) begin
            from_sel = r_ptr;
        end
    end

    always_comb begin
        n_busy = r_busy;
        n_ptr  = r_ptr;
        if (i_start_all) begin
            n_busy = 1'b1;
            n_ptr  = '0;
        end else if (i_start_from) begin
            n_busy = (from_sel < LIMIT);
            n_ptr  = from_sel;
        end else if (r_busy) begin
            n_busy = (r_ptr != LAST);
            n_ptr  = r_ptr + LEN_W'(1);
        end
    end

    // reset starts a full sweep
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r_ptr  <= '0;
        end else begin
            r_busy <= n_busy;
            r_ptr  <= n_ptr;
        end
    end

    assign o_busy = r_busy;
    assign o_addr = r_ptr[AW-1:0];

endmodule

FILE: rtl/arb_pos.sv
// Request decode and position update: next read/write positions, range error, slot address.
module arb_pos
    import arb_pkg::*;
#(
    parameter int DEPTH  = 4096,
    localparam int AW    = $clog2(DEPTH),
    localparam int LEN_W = $clog2(DEPTH + 1),
    localparam int SW    = LEN_W + 1
) (
    input  logic [FUNC_W-1:0] i_func,
    input  logic [LEN_W-1:0]  i_amount,
    input  logic [AW-1:0]     i_position,
    input  logic [AW-1:0]     i_rd_pos,
    input  logic [AW-1:0]     i_wr_pos,
    input  logic [LEN_W-1:0]  i_len,
    output logic [AW-1:0]     o_rd_pos,
    output logic [AW-1:0]     o_wr_pos,
    output logic              o_err,
    output logic [AW-1:0]     o_addr,
    output t_op               o_op
);

    logic [SW-1:0] rd_inc, wr_inc, adv_sum;
    logic [AW-1:0] rd_step, wr_step, adv_base, adv_pos;
    logic          amt_bad, pos_bad;

    // single steps and the advance, each wrapping with one compare
    always_comb begin
        rd_inc   = SW'(i_rd_pos) + SW'(1);
        wr_inc   = SW'(i_wr_pos) + SW'(1);
        rd_step  = (rd_inc >= SW'(i_len)) ? '0 : rd_inc[AW-1:0];
        wr_step  = (wr_inc >= SW'(i_len)) ? '0 : wr_inc[AW-1:0];
        adv_base = (i_func == FUNC_ADV_READ) ? i_rd_pos : i_wr_pos;
        adv_sum  = SW'(adv_base) + SW'(i_amount);
        if (adv_sum >= SW'(i_len)) begin
            adv_sum = adv_sum - SW'(i_len);
        end
        adv_pos  = adv_sum[AW-1:0];
        amt_bad  = (i_amount > i_len);
        pos_bad  = (LEN_W'(i_position) >= i_len);
    end

    // per-request decode
    always_comb begin
        o_rd_pos = i_rd_pos;
        o_wr_pos = i_wr_pos;
        o_err    = 1'b0;
        o_addr   = i_wr_pos;
        o_op     = '0;
        case (i_func)
            FUNC_WRITE: begin
                o_op.wr_en = 1'b1;
                o_wr_pos   = wr_step;
            end
            FUNC_WRITE_ADD: begin
                o_op.wr_en  = 1'b1;
                o_op.wr_add = 1'b1;
                o_wr_pos    = wr_step;
            end
            FUNC_READ: begin
                o_addr      = i_rd_pos;
                o_op.rd_res = 1'b1;
                o_rd_pos    = rd_step;
            end
            FUNC_READ_ADD: begin
                o_addr      = i_rd_pos;
                o_op.rd_res = 1'b1;
                o_op.rd_add = 1'b1;
                o_rd_pos    = rd_step;
            end
            FUNC_READ_ADD_CLR: begin
                o_addr       = i_rd_pos;
                o_op.rd_res  = 1'b1;
                o_op.rd_add  = 1'b1;
                o_op.wr_en   = 1'b1;
                o_op.wr_zero = 1'b1;
                o_rd_pos     = rd_step;
            end
            FUNC_CLEAR_SLOT: begin
                o_op.wr_en   = 1'b1;
                o_op.wr_zero = 1'b1;
                o_wr_pos     = wr_step;
            end
            FUNC_ADV_WRITE: begin
                if (amt_bad) o_err = 1'b1;
                else         o_wr_pos = adv_pos;
            end
            FUNC_ADV_READ: begin
                if (amt_bad) o_err = 1'b1;
                else         o_rd_pos = adv_pos;
            end
            FUNC_SET_WRITE: begin
                if (pos_bad) o_err = 1'b1;
                else         o_wr_pos = i_position;
            end
            FUNC_SET_READ: begin
                if (pos_bad) o_err = 1'b1;
                else         o_rd_pos = i_position;
            end
            FUNC_SET_BOTH: begin
                if (pos_bad) begin
                    o_err = 1'b1;
                end else begin
                    o_rd_pos = i_position;
                    o_wr_pos = i_position;
                end
            end
            FUNC_RD_TO_WR: begin
                o_wr_pos = i_rd_pos;
            end
            FUNC_WR_TO_RD: begin
                o_rd_pos = i_wr_pos;
            end
            FUNC_CLEAR_ALL: begin
                o_op.clr_all = 1'b1;
            end
            default: begin
            end
        endcase
    end

endmodule

FILE: rtl/audio_ring_buffer_accumulator.sv
// Top level of the audio ring buffer with overlap-add.
//
// Input channel (i_in_valid / o_in_ready) takes one request: func, sample, amount
// and position. Output channel (o_out_valid / i_out_ready) returns one result per
// request: sample, read and write positions after the request, and a range error.
// The register port holds ring_length at address 0; writing it resets both
// positions and zeroes all slots at or above the new length.
// Pipeline: the slot is read from the sample memory at the accept edge, the
// second stage adds, saturates and writes back, and the result sits in an output
// register. Results leave the second stage for the output register in order.
// Throughput is one request per cycle while no sweep runs and the receiver takes
// results, bounded by the single memory write port; a read that hits the slot
// written in the same cycle is forwarded. clear_all holds o_in_ready low while
// the sweeper zeroes all slots, one per cycle; a length write zeroes only those
// from the new length up. After reset the same sweep runs over all DEPTH slots
// (4096 by default) before the first request is taken; register writes are taken
// during it. When the receiver stalls, the output register holds its result, the
// second stage holds one more, and o_in_ready drops until space opens.
module audio_ring_buffer_accumulator
    import arb_pkg::*;
#(
    parameter int DEPTH       = DEF_DEPTH,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
    localparam int AW         = $clog2(DEPTH),
    localparam int LEN_W      = $clog2(DEPTH + 1)
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // request channel
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic [FUNC_W-1:0]      i_func,
    input  logic [SAMPLE_BITS-1:0] i_sample_in,
    input  logic [LEN_W-1:0]       i_amount,
    input  logic [AW-1:0]          i_position,
    // result channel
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [SAMPLE_BITS-1:0] o_sample_out,
    output logic [AW-1:0]          o_read_position,
    output logic [AW-1:0]          o_write_position,
    output logic                   o_error,
    // register port
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [PADDR_W-1:0]     paddr,
    input  logic [APB_DW-1:0]      pwdata,
    output logic [APB_DW-1:0]      prdata,
    output logic                   pready
);

    localparam int SB = SAMPLE_BITS;
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(DEPTH);
    localparam int RST_LEN = (RST_RING_LENGTH < DEPTH) ? RST_RING_LENGTH : DEPTH;
    localparam logic [SB-1:0] SMP_MAX = {1'b0, {(SB-1){1'b1}}};
    localparam logic [SB-1:0] SMP_MIN = {1'b1, {(SB-1){1'b0}}};

    function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] raw);
        logic [LEN_W-1:0] v;
        v = raw;
        if (raw == '0)          v = LEN_W'(1);
        else if (raw > LEN_MAX) v = LEN_MAX;
        return v;
    endfunction

    // register port
    logic             cfg_wr;
    logic [LEN_W-1:0] cfg_raw;
    logic [LEN_W-1:0] r_ring_length;
    logic [LEN_W-1:0] len;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && (paddr[2] == REG_RING_LENGTH);
    assign cfg_raw = pwdata[LEN_W-1:0];
    assign prdata  = (paddr[2] == REG_RING_LENGTH) ? APB_DW'(r_ring_length) : '0;
    assign len     = eff_len(r_ring_length);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring_length <= LEN_W'(RST_LEN);
        end else if (cfg_wr) begin
            r_ring_length <= cfg_raw;
        end
    end

    // request decode and positions
    logic [AW-1:0] r_rd_pos, r_wr_pos;
    logic [AW-1:0] pos_rd, pos_wr, pos_addr;
    logic          pos_err;
    t_op           pos_op;

    arb_pos #(
        .DEPTH (DEPTH)
    ) u_pos (
        .i_func     (i_func),
        .i_amount   (i_amount),
        .i_position (i_position),
        .i_rd_pos   (r_rd_pos),
        .i_wr_pos   (r_wr_pos),
        .i_len      (len),
        .o_rd_pos   (pos_rd),
        .o_wr_pos   (pos_wr),
        .o_err      (pos_err),
        .o_addr     (pos_addr),
        .o_op       (pos_op)
    );

    // handshake
    logic clr_busy;
    logic [AW-1:0] clr_addr;
    logic r_s2_vld, r_out_vld;
    logic out_free, s2_fire, in_acc;

    assign out_free   = !r_out_vld || i_out_ready;
    assign s2_fire    = r_s2_vld && out_free;
    assign o_in_ready = !clr_busy && (!r_s2_vld || out_free);
    assign in_acc     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_pos <= '0;
            r_wr_pos <= '0;
        end else if (cfg_wr) begin
            r_rd_pos <= '0;
            r_wr_pos <= '0;
        end else if (in_acc) begin
            r_rd_pos <= pos_rd;
            r_wr_pos <= pos_wr;
        end
    end

    // clear sweeper
    arb_clr #(
        .DEPTH (DEPTH)
    ) u_clr (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start_all  (in_acc && pos_op.clr_all),
        .i_start_from (cfg_wr),
        .i_from       (eff_len(cfg_raw)),
        .o_busy       (clr_busy),
        .o_addr       (clr_addr)
    );

    // second stage registers
    t_op           r_s2_op;
    logic [AW-1:0] r_s2_addr, r_s2_rd, r_s2_wr;
    logic [SB-1:0] r_s2_smp;
    logic          r_s2_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else if (in_acc) begin
            r_s2_vld <= 1'b1;
        end else if (s2_fire) begin
            r_s2_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s2_op   <= pos_op;
            r_s2_addr <= pos_addr;
            r_s2_rd   <= pos_rd;
            r_s2_wr   <= pos_wr;
            r_s2_smp  <= i_sample_in;
            r_s2_err  <= pos_err;
        end
    end

    // sample memory
    logic          s2_we, ram_we;
    logic [AW-1:0] ram_waddr;
    logic [SB-1:0] ram_wdata, ram_q, s2_wdata;

    assign s2_we     = s2_fire && r_s2_op.wr_en;
    assign ram_we    = clr_busy || s2_we;
    assign ram_waddr = clr_busy ? clr_addr : r_s2_addr;
    assign ram_wdata = clr_busy ? '0 : s2_wdata;

    arb_ram #(
        .DEPTH (DEPTH),
        .WIDTH (SB)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (in_acc),
        .i_raddr (pos_addr),
        .o_rdata (ram_q)
    );

    // forward the last write-back to a read issued at the same edge
    logic          r_fwd_vld;
    logic [AW-1:0] r_fwd_addr;
    logic [SB-1:0] r_fwd_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_vld <= 1'b0;
        end else if (clr_busy) begin
            r_fwd_vld <= 1'b0;
        end else if (s2_fire) begin
            r_fwd_vld <= r_s2_op.wr_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_we) begin
            r_fwd_addr <= r_s2_addr;
            r_fwd_data <= s2_wdata;
        end
    end

    // saturating add and result select
    logic [SB-1:0] slot_val, sum_sat, s2_res;
    logic [SB:0]   sum;

    always_comb begin
        slot_val = (r_fwd_vld && (r_fwd_addr == r_s2_addr)) ? r_fwd_data : ram_q;
        sum      = {slot_val[SB-1], slot_val} + {r_s2_smp[SB-1], r_s2_smp};
        if (sum[SB] != sum[SB-1]) sum_sat = sum[SB] ? SMP_MIN : SMP_MAX;
        else                      sum_sat = sum[SB-1:0];
        if (r_s2_op.wr_zero)     s2_wdata = '0;
        else if (r_s2_op.wr_add) s2_wdata = sum_sat;
        else                     s2_wdata = r_s2_smp;
        if (!r_s2_op.rd_res)     s2_res = '0;
        else if (r_s2_op.rd_add) s2_res = sum_sat;
        else                     s2_res = slot_val;
    end

    // output register
    logic [SB-1:0] r_out_smp;
    logic [AW-1:0] r_out_rd, r_out_wr;
    logic          r_out_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s2_fire) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_fire) begin
            r_out_smp <= s2_res;
            r_out_rd  <= r_s2_rd;
            r_out_wr  <= r_s2_wr;
            r_out_err <= r_s2_err;
        end
    end

    assign o_out_valid      = r_out_vld;
    assign o_sample_out     = r_out_smp;
    assign o_read_position  = r_out_rd;
    assign o_write_position = r_out_wr;
    assign o_error          = r_out_err;

endmodule

FILE: rtl/arb_checker.sv
// Port-level checker for the audio ring buffer, bound to the top level.
`include "audio_ring_buffer_accumulator_defines.svh"

module arb_checker
    import arb_pkg::*;
#(
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_in_valid,
    input logic                   i_in_ready,
    input logic [FUNC_W-1:0]      i_func,
    input logic                   i_out_valid,
    input logic                   i_out_ready,
    input logic [SAMPLE_BITS-1:0] i_sample_out,
    input logic                   i_error
);

    logic in_acc;
    assign in_acc = i_in_valid && i_in_ready;

    // a stalled result stays offered
    `ARB_ASSERT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid, "result dropped while stalled")
    // every accepted request has a result waiting after the second and output stages
    `ARB_ASSERT(a_latency, i_clk, i_rst_n, in_acc |-> ##2 i_out_valid, "result missing two cycles after request")
    // clear_all blocks new requests while the sweep runs
    `ARB_ASSERT(a_clr_block, i_clk, i_rst_n, in_acc && (i_func == FUNC_CLEAR_ALL) |=> !i_in_ready, "request taken during clear sweep")
    // range errors only come from position requests, which carry no sample
    `ARB_ASSERT(a_err_zero, i_clk, i_rst_n, i_out_valid && i_error |-> (i_sample_out == '0), "error result with nonzero sample")
    // the memory clear after reset holds off requests
    `ARB_ASSERT_ANY(a_rst_clear, i_clk, !i_rst_n |=> !i_in_ready, "request taken right after reset")

endmodule

bind audio_ring_buffer_accumulator arb_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_arb_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .i_in_ready   (o_in_ready),
    .i_func       (i_func),
    .i_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .i_sample_out (o_sample_out),
    .i_error      (o_error)
);
